// ===== sv/lsac_pkg.sv =====
// Shared constants for the LRU set-associative cache hit/miss core.
// Field widths, configuration register indexes and stream packing widths.
// No dependencies.
package lsac_pkg;

  // Address bits that can ever be meaningful.
  localparam int ADDR_W = 32;

  localparam int DEF_MAX_SETS = 64;
  localparam int DEF_MAX_WAYS = 8;

  // Field widths
  localparam int ADDRESS_W    = 32;
  localparam int SET_INDEX_W  = 6;
  localparam int WAY_USED_W   = 3;
  localparam int MISS_TOTAL_W = 32;

  // Largest index width the set number may use
  localparam int IDX_MAX = 6;

  // Configuration register widths
  localparam int AW_W  = 6;
  localparam int OB_W  = 5;
  localparam int IB_W  = 3;
  localparam int WY_W  = 4;
  localparam int CFG_DATA_W  = 6;
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ADDRESS_WIDTH = 2'd0,
    REG_OFFSET_BITS   = 2'd1,
    REG_INDEX_BITS    = 2'd2,
    REG_WAYS_IN_USE   = 2'd3
  } cfg_reg_t;

  localparam logic [AW_W-1:0] AW_RESET = 6'd32;
  localparam logic [OB_W-1:0] OB_RESET = 5'd0;
  localparam logic [IB_W-1:0] IB_RESET = 3'd0;
  localparam logic [WY_W-1:0] WY_RESET = 4'd1;

  // Stream payload widths, padded to whole bytes
  localparam int S_TDATA_W = 32;
  localparam int M_FIELDS_W = 1 + SET_INDEX_W + WAY_USED_W + MISS_TOTAL_W;
  localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;

endpackage

// ===== sv/lru_set_assoc_cache_hit_miss_core.sv =====
// Tag-only set-associative cache with true LRU replacement and a miss counter.
// Holds the set memory, the lookup/update stage and the result register.
// Depends on lsac_pkg.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tdata: address
//  m_*     | out | m_tvalid/m_tready  | m_tdata: hit, set_index, way_used, miss_total
//  cfg_*   | in  | cfg_we             | cfg_index, cfg_data
//
// One address is taken per cycle while the result is not stalled. Each address has its
// split registered and its set row read from the two-port memory; the lookup stage
// compares all ways in parallel, writes the updated row back and loads the result register.
// A row written in the cycle before is taken from a bypass register.
// Reset is synchronous; per-set init bits make untouched sets read as empty.
// A stalled result holds the lookup stage, which holds the input.
module lru_set_assoc_cache_hit_miss_core #(
  parameter int MAX_SETS = lsac_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS = lsac_pkg::DEF_MAX_WAYS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [31:0] address
  input  logic [lsac_pkg::S_TDATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] hit, [6:1] set_index, [9:7] way_used, [41:10] miss_total, rest zero
  output logic [lsac_pkg::M_TDATA_W-1:0]      m_tdata,
  input  logic                                cfg_we,
  input  logic [lsac_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lsac_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lsac_pkg::*;

  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CNT_W = $clog2(MAX_WAYS + 1);
  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int NSETNUM = 1 << IDX_MAX;

  typedef logic [NSETNUM-1:0][SET_INDEX_W-1:0] set_tab_t;

  typedef struct packed {
    logic [MAX_WAYS-1:0][ADDRESS_W-1:0] tag;
    logic [MAX_WAYS-1:0][WAY_W-1:0]     age;
    logic [MAX_WAYS-1:0]                vld;
  } row_t;

  // Set number folded onto the sets present
  function automatic set_tab_t build_set_tab();
    set_tab_t t;
    for (int i = 0; i < NSETNUM; i++) begin
      t[i] = SET_INDEX_W'(i % MAX_SETS);
    end
    return t;
  endfunction

  localparam set_tab_t SET_TAB = build_set_tab();

  // Configuration
  logic [AW_W-1:0] aw_r;
  logic [OB_W-1:0] ob_r;
  logic [IB_W-1:0] ib_r;
  logic [WY_W-1:0] wy_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      aw_r <= AW_RESET;
      ob_r <= OB_RESET;
      ib_r <= IB_RESET;
      wy_r <= WY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ADDRESS_WIDTH: aw_r <= cfg_data[AW_W-1:0];
        REG_OFFSET_BITS:   ob_r <= cfg_data[OB_W-1:0];
        REG_INDEX_BITS:    ib_r <= cfg_data[IB_W-1:0];
        REG_WAYS_IN_USE:   wy_r <= cfg_data[WY_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake
  logic s1_valid;
  logic s1_fire;
  logic s_fire;

  assign s1_fire  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_fire;
  assign s_fire   = s_tvalid && s_tready;

  // Address split
  logic [AW_W-1:0]        aw_c;
  logic [IB_W-1:0]        ib_c;
  logic [ADDRESS_W-1:0]   amask;
  logic [ADDRESS_W-1:0]   addr_m;
  logic [SET_INDEX_W-1:0] imask;
  logic [SET_INDEX_W-1:0] setnum;
  logic [SET_INDEX_W-1:0] set_a;
  logic [SET_W-1:0]       row_a;
  logic [ADDRESS_W-1:0]   tag_a;

  always_comb begin
    if (aw_r == '0) begin
      aw_c = AW_W'(1);
    end else if (aw_r > AW_W'(ADDR_W)) begin
      aw_c = AW_W'(ADDR_W);
    end else begin
      aw_c = aw_r;
    end
    ib_c   = (ib_r > IB_W'(IDX_MAX)) ? IB_W'(IDX_MAX) : ib_r;
    amask  = (aw_c >= AW_W'(ADDRESS_W)) ? '1
           : ADDRESS_W'(({1'b0, {ADDRESS_W{1'b0}}} | (33'd1 << aw_c)) - 33'd1);
    addr_m = s_tdata[ADDRESS_W-1:0] & amask;
    imask  = SET_INDEX_W'((7'd1 << ib_c) - 7'd1);
    setnum = SET_INDEX_W'(addr_m >> ob_r) & imask;
    set_a  = SET_TAB[setnum];
    row_a  = SET_W'(set_a);
    tag_a  = addr_m >> (6'(ob_r) + 6'(ib_c));
  end

  // Set memory and per-set init bits
  row_t             mem [MAX_SETS];
  logic [MAX_SETS-1:0] row_init;
  row_t             rd_row;
  logic             rd_init;

  // Lookup stage registers
  logic [SET_INDEX_W-1:0] s1_set;
  logic [SET_W-1:0]       s1_row;
  logic [ADDRESS_W-1:0]   s1_tag;

  // Bypass of the last written row
  logic             last_valid;
  logic [SET_W-1:0] last_set;
  row_t             last_row;

  row_t nxt;

  always_ff @(posedge clk) begin
    if (s_fire) begin
      rd_row <= mem[row_a];
      rd_init <= row_init[row_a];
      s1_set <= set_a;
      s1_row <= row_a;
      s1_tag <= tag_a;
    end
    if (s1_fire) begin
      mem[s1_row] <= nxt;
      last_set <= s1_row;
      last_row <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_init <= '0;
      last_valid <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (s1_fire) begin
        row_init[s1_row] <= 1'b1;
        last_valid <= 1'b1;
      end
      if (s_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Lookup and LRU update
  row_t                cur;
  logic [CNT_W-1:0]    ways_c;
  logic [MAX_WAYS-1:0] in_use;
  logic                hit_any;
  logic                free_any;
  logic [WAY_W-1:0]    hit_w;
  logic [WAY_W-1:0]    free_w;
  logic [WAY_W-1:0]    vic_w;
  logic [WAY_W-1:0]    best;
  logic [WAY_W-1:0]    way_sel;
  logic                was_valid;
  logic [CNT_W-1:0]    old_age;

  always_comb begin
    if (last_valid && last_set == s1_row) begin
      cur = last_row;
    end else if (rd_init) begin
      cur = rd_row;
    end else begin
      cur = '0;
    end

    if (wy_r == '0) begin
      ways_c = CNT_W'(1);
    end else if (int'(wy_r) > MAX_WAYS) begin
      ways_c = CNT_W'(MAX_WAYS);
    end else begin
      ways_c = CNT_W'(wy_r);
    end

    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_w    = '0;
    free_w   = '0;
    for (int k = MAX_WAYS - 1; k >= 0; k--) begin
      in_use[k] = CNT_W'(k) < ways_c;
      if (in_use[k] && cur.vld[k] && cur.tag[k] == s1_tag) begin
        hit_any = 1'b1;
        hit_w   = WAY_W'(k);
      end
      if (in_use[k] && !cur.vld[k]) begin
        free_any = 1'b1;
        free_w   = WAY_W'(k);
      end
    end

    // Oldest way; a tie keeps the lowest
    best  = '0;
    vic_w = '0;
    for (int k = 0; k < MAX_WAYS; k++) begin
      if (in_use[k] && cur.age[k] > best) begin
        best  = cur.age[k];
        vic_w = WAY_W'(k);
      end
    end

    if (hit_any) begin
      way_sel = hit_w;
    end else if (free_any) begin
      way_sel = free_w;
    end else begin
      way_sel = vic_w;
    end
    was_valid = hit_any || !free_any;
    old_age   = was_valid ? CNT_W'(cur.age[way_sel]) : CNT_W'(MAX_WAYS);

    nxt = cur;
    for (int k = 0; k < MAX_WAYS; k++) begin
      if (WAY_W'(k) != way_sel && in_use[k] && cur.vld[k]
          && CNT_W'(cur.age[k]) < old_age
          && CNT_W'(cur.age[k]) < ways_c - CNT_W'(1)) begin
        nxt.age[k] = cur.age[k] + WAY_W'(1);
      end
    end
    nxt.age[way_sel] = '0;
    if (!hit_any) begin
      nxt.tag[way_sel] = s1_tag;
      nxt.vld[way_sel] = 1'b1;
    end
  end

  // Miss counter and result register
  logic [MISS_TOTAL_W-1:0] miss_cnt;
  logic [MISS_TOTAL_W-1:0] miss_cnt_next;
  logic                    r_hit;
  logic [SET_INDEX_W-1:0]  r_set;
  logic [WAY_USED_W-1:0]   r_way;

  always_comb begin
    miss_cnt_next = miss_cnt;
    if (!hit_any && miss_cnt != '1) begin
      miss_cnt_next = miss_cnt + MISS_TOTAL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      miss_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (s1_fire) begin
        miss_cnt <= miss_cnt_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      r_hit <= hit_any;
      r_set <= s1_set;
      r_way <= WAY_USED_W'(way_sel);
    end
  end

  assign m_tdata = {(M_TDATA_W - M_FIELDS_W)'(0), miss_cnt, r_way, r_set, r_hit};

`ifndef SYNTHESIS
  a_hit_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && hit_any) |=> miss_cnt == $past(miss_cnt))
    else $error("miss count moved on a hit");

  a_way_in_use: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (CNT_W'(way_sel) < ways_c))
    else $error("selected way outside the ways in use");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> m_tvalid)
    else $error("lookup transfer produced no result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for lru_set_assoc_cache_hit_miss_core.
// Holds an LRU shadow of the cache that predicts every lookup, plus stream drivers and monitors.
// Depends on lsac_pkg and the core RTL.
module tb;
  import lsac_pkg::*;

  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    logic                    hit;
    logic [SET_INDEX_W-1:0]  set_idx;
    logic [WAY_USED_W-1:0]   way;
    logic [MISS_TOTAL_W-1:0] misses;
  } lookup_t;

  function automatic logic [63:0] ones(int n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  class lru_shadow;
    logic [31:0]     tags   [DEF_MAX_SETS*DEF_MAX_WAYS];
    bit              valid  [DEF_MAX_SETS*DEF_MAX_WAYS];
    bit [2:0]        ages   [DEF_MAX_SETS*DEF_MAX_WAYS];
    logic [31:0]     misses;
    logic [AW_W-1:0] aw_reg;
    logic [OB_W-1:0] ob_reg;
    logic [IB_W-1:0] ib_reg;
    logic [WY_W-1:0] wy_reg;
    lookup_t         lookups_due[$];
    int              errors;

    function new();
      foreach (tags[i]) begin
        tags[i]  = '0;
        valid[i] = 1'b0;
        ages[i]  = '0;
      end
      misses  = '0;
      aw_reg  = AW_RESET;
      ob_reg  = OB_RESET;
      ib_reg  = IB_RESET;
      wy_reg  = WY_RESET;
      errors  = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_ADDRESS_WIDTH: aw_reg = v[AW_W-1:0];
        REG_OFFSET_BITS:   ob_reg = v[OB_W-1:0];
        REG_INDEX_BITS:    ib_reg = v[IB_W-1:0];
        REG_WAYS_IN_USE:   wy_reg = v[WY_W-1:0];
        default: ;
      endcase
    endfunction

    // Make way w most recent; valid ways younger than its old age move up one.
    function void refresh(int base, int nw, int w, bit was_valid);
      int old;
      old = was_valid ? int'(ages[base+w]) : DEF_MAX_WAYS;
      for (int k = 0; k < nw; k++) begin
        if (k != w && valid[base+k] && ages[base+k] < old && ages[base+k] < nw - 1)
          ages[base+k]++;
      end
      ages[base+w] = '0;
    endfunction

    function void note_access(logic [31:0] addr);
      int          aw, ib, nw, base, way;
      logic [63:0] a, setnum, tag;
      bit          hit, free;
      lookup_t     e;
      aw = int'(aw_reg);
      if (aw < 1) aw = 1;
      if (aw > ADDR_W) aw = ADDR_W;
      ib = (ib_reg > IDX_MAX) ? IDX_MAX : int'(ib_reg);
      nw = int'(wy_reg);
      if (nw < 1) nw = 1;
      if (nw > DEF_MAX_WAYS) nw = DEF_MAX_WAYS;
      a      = {32'd0, addr} & ones(aw);
      setnum = (a >> ob_reg) & ones(ib);
      tag    = a >> (int'(ob_reg) + ib);
      base   = int'(setnum[5:0]) * DEF_MAX_WAYS;
      hit  = 1'b0;
      free = 1'b0;
      way  = 0;
      for (int k = 0; k < nw; k++) begin
        if (!hit && valid[base+k] && tags[base+k] == tag[31:0]) begin
          hit = 1'b1;
          way = k;
        end
      end
      if (hit) begin
        refresh(base, nw, way, 1'b1);
      end else begin
        for (int k = 0; k < nw; k++) begin
          if (!free && !valid[base+k]) begin
            free = 1'b1;
            way  = k;
          end
        end
        if (free) begin
          refresh(base, nw, way, 1'b0);
          valid[base+way] = 1'b1;
        end else begin
          // oldest way wins, lowest way on a tie
          way = 0;
          for (int k = 1; k < nw; k++) begin
            if (ages[base+k] > ages[base+way]) way = k;
          end
          refresh(base, nw, way, 1'b1);
        end
        tags[base+way] = tag[31:0];
        if (misses != '1) misses++;
      end
      e.hit     = hit;
      e.set_idx = setnum[5:0];
      e.way     = way[2:0];
      e.misses  = misses;
      lookups_due.push_back(e);
    endfunction

    function void mismatch(string field, longint unsigned want, longint unsigned got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_lookup(logic [M_TDATA_W-1:0] d);
      lookup_t e;
      if (lookups_due.size() == 0) begin
        mismatch("unexpected result", 0, d);
        return;
      end
      e = lookups_due.pop_front();
      if (d[0] !== e.hit) mismatch("hit", e.hit, d[0]);
      if (d[6:1] !== e.set_idx) mismatch("set_index", e.set_idx, d[6:1]);
      if (d[9:7] !== e.way) mismatch("way_used", e.way, d[9:7]);
      if (d[41:10] !== e.misses) mismatch("miss_total", e.misses, d[41:10]);
      if (d[M_TDATA_W-1:M_FIELDS_W] !== '0)
        mismatch("padding", 0, d[M_TDATA_W-1:M_FIELDS_W]);
    endfunction
  endclass

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  lru_shadow shadow = new();
  bit        steady  = 1'b0;
  bit        rx_hold = 1'b0;
  int        quiet_cycles = 0;

  lru_set_assoc_cache_hit_miss_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: random back-pressure, a steady stretch, and one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        rx_hold = 1'b0;
        m_tready <= 1'b0;
        repeat (80) @(posedge clk);
      end else if (steady) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 22);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) shadow.check_lookup(m_tdata);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [31:0] addr);
    while (!steady && $urandom_range(99) < 22) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= addr;
    do @(posedge clk); while (!s_tready);
    shadow.note_access(addr);
  endtask

  // Drop valid and hold until every predicted lookup has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (shadow.lookups_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    shadow.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic apply_setting(input int aw, input int ob, input int ib, input int wy);
    write_cfg(REG_ADDRESS_WIDTH, 6'(aw));
    write_cfg(REG_OFFSET_BITS, 6'(ob));
    write_cfg(REG_INDEX_BITS, 6'(ib));
    write_cfg(REG_WAYS_IN_USE, 6'(wy));
    cfg_we <= 1'b0;
  endtask

  // Mostly a few tags over a few sets so that hits and evictions recur; some raw addresses.
  function automatic logic [31:0] pick_addr(int eaw, int ob, int eib, int ew);
    logic [63:0] a, setv, tagv, junk;
    if ($urandom_range(99) < 15) return $urandom;
    setv = (($urandom_range(3) == 0) ? 64'($urandom) : 64'($urandom_range(0, 3))) & ones(eib);
    tagv = 64'($urandom_range(0, ew + 2));
    a    = (tagv << (ob + eib)) | (setv << ob) | ({32'd0, $urandom} & ones(ob));
    junk = {32'd0, $urandom};
    a    = (a & ones(eaw)) | (junk & ~ones(eaw));
    return a[31:0];
  endfunction

  task automatic run_phase(input int aw, input int ob, input int ib, input int wy,
                           input int n, input int hold_at);
    int eaw, eib, ew;
    eaw = (aw < 1) ? 1 : ((aw > ADDR_W) ? ADDR_W : aw);
    eib = (ib > IDX_MAX) ? IDX_MAX : ib;
    ew  = (wy < 1) ? 1 : ((wy > DEF_MAX_WAYS) ? DEF_MAX_WAYS : wy);
    apply_setting(aw, ob, ib, wy);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) rx_hold = 1'b1;
      send_item(pick_addr(eaw, ob, eib, ew));
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: one direct-mapped way, full address as tag.
    send_item(32'h0000_0000);
    send_item(32'h0000_0000);
    send_item(32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF);
    drain();

    // Four ways, set 1: fill, hit, evict the oldest, hit again.
    apply_setting(32, 4, 2, 4);
    for (int t = 1; t <= 4; t++) send_item(32'((t << 6) | (1 << 4) | t));
    send_item(32'((1 << 6) | (1 << 4) | 15));
    send_item(32'((5 << 6) | (1 << 4)));
    send_item(32'((3 << 6) | (1 << 4)));
    drain();

    // Shrink to two ways without a flush; the upper ways keep stale tags.
    apply_setting(32, 4, 2, 2);
    send_item(32'((9 << 6) | (1 << 4)));
    send_item(32'((4 << 6) | (1 << 4)));
    drain();

    // Zero width, oversized index and zero ways act as their clamped values.
    apply_setting(0, 31, 7, 0);
    send_item(32'hFFFF_FFFF);
    send_item(32'h0000_0000);
    send_item(32'h0000_0001);
    drain();

    apply_setting(63, 0, 6, 15);
    send_item(32'hFFFF_FFFF);
    send_item(32'hFFFF_FFC0);
    send_item(32'hFFFF_FFFF);
    drain();

    // Offset plus index past the address width: tag is zero, high index bits read zero.
    apply_setting(8, 4, 6, 8);
    send_item(32'hFFFF_FFFF);
    send_item(32'h0000_00A5);
    send_item(32'h1234_5600);
    drain();

    run_phase(32, 0, 0, 8, 230, -1);
    run_phase(12, 2, 3, 4, 230, 60);
    run_phase(63, 31, 7, 15, 230, -1);
    run_phase(1, 0, 6, 1, 230, -1);
    steady = 1'b1;
    run_phase(20, 5, 6, 8, 230, -1);
    steady = 1'b0;
    run_phase($urandom_range(0, 63), $urandom_range(0, 8), $urandom_range(0, 7),
              $urandom_range(0, 15), 230, -1);
    run_phase($urandom_range(0, 63), $urandom_range(0, 31), $urandom_range(0, 7),
              $urandom_range(0, 15), 230, -1);
    run_phase(16, 1, 2, 3, 230, -1);

    repeat (10) @(posedge clk);
    if (shadow.errors == 0 && shadow.lookups_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
